// ===== design/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, constants and helper functions for the rectangular to polar
// converter (CORDIC vectoring, phase in 1/128 degree).
// ----------------------------------------------------------------------------
package cpd_pkg;

	localparam int MAG_W      = 16;
	localparam int PHASE_W    = 17;
	localparam int GUARD_BITS = 8;
	localparam int ZW         = 26;   // angle accumulator, 2^-16 degree units
	localparam int PHASE_SHIFT = 9;   // 2^-16 deg -> 1/128 deg
	localparam int GAIN_W     = 22;
	localparam int MAG_SHIFT  = 30;

	localparam logic REQ_RECT  = 1'b0;
	localparam logic REQ_POLAR = 1'b1;

	localparam logic [GAIN_W-1:0]      INV_GAIN     = 22'd2547003;  // 1/K in Q22
	localparam logic [MAG_SHIFT-1:0]   MAG_ROUND    = 30'h2000_0000;
	localparam logic [MAG_W-1:0]       MAG_MAX      = 16'hFFFF;
	localparam logic signed [ZW-1:0]   Z_HALF_TURN  = 26'sd11796480; // 180 deg
	localparam logic signed [ZW-1:0]   Z_ROUND      = 26'sd256;
	localparam logic signed [PHASE_W-1:0] HALF_TURN = 17'sd23040;
	localparam logic signed [PHASE_W:0]   HALF_TURN_X = 18'sd23040;
	localparam logic signed [PHASE_W:0]   FULL_TURN_X = 18'sd46080;

	typedef struct packed {
		logic                      direct;  // result known without rotation
		logic [MAG_W-1:0]          mag;
		logic signed [PHASE_W-1:0] phase;
	} cpd_direct_t;

	// atan(2^-idx) in degrees, scaled by 2^16
	function automatic logic signed [ZW-1:0] atan_step(input int idx);
		logic signed [ZW-1:0] r;
		case (idx)
			0:  r = 26'sd2949120;
			1:  r = 26'sd1740967;
			2:  r = 26'sd919879;
			3:  r = 26'sd466945;
			4:  r = 26'sd234379;
			5:  r = 26'sd117304;
			6:  r = 26'sd58666;
			7:  r = 26'sd29335;
			8:  r = 26'sd14668;
			9:  r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// single wrap into [-180, 180] degrees
	function automatic logic signed [PHASE_W-1:0] wrap_phase(
		input logic signed [PHASE_W-1:0] p
	);
		logic signed [PHASE_W:0] pw;
		pw = (PHASE_W+1)'(p);
		if (pw > HALF_TURN_X) begin
			pw = pw - FULL_TURN_X;
		end else if (pw < -HALF_TURN_X) begin
			pw = pw + FULL_TURN_X;
		end
		return pw[PHASE_W-1:0];
	endfunction

endpackage

// ===== design/cpd_in_if.sv =====
// ----------------------------------------------------------------------------
// cpd_in_if
// Request channel: rectangular sample or polar pair, valid/ready.
// ----------------------------------------------------------------------------
interface cpd_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic signed [SAMPLE_WIDTH-1:0]       real_part;
	logic signed [SAMPLE_WIDTH-1:0]       imag_part;
	logic [cpd_pkg::MAG_W-1:0]            given_magnitude;
	logic signed [cpd_pkg::PHASE_W-1:0]   given_phase;

	modport source (
		output valid, req_type, real_part, imag_part, given_magnitude, given_phase,
		input  ready
	);
	modport sink (
		input  valid, req_type, real_part, imag_part, given_magnitude, given_phase,
		output ready
	);
endinterface

// ===== design/cpd_out_if.sv =====
// ----------------------------------------------------------------------------
// cpd_out_if
// Result channel: magnitude and wrapped phase, valid/ready.
// ----------------------------------------------------------------------------
interface cpd_out_if;
	logic                               valid;
	logic                               ready;
	logic [cpd_pkg::MAG_W-1:0]          magnitude;
	logic signed [cpd_pkg::PHASE_W-1:0] phase_deg;

	modport source (
		output valid, magnitude, phase_deg,
		input  ready
	);
	modport sink (
		input  valid, magnitude, phase_deg,
		output ready
	);
endinterface

// ===== design/cpd_prep.sv =====
// ----------------------------------------------------------------------------
// cpd_prep
// Entry stage: sign extension, left half plane fold, start angle, and the
// results that need no rotation (polar pair, sample on the real axis).
// ----------------------------------------------------------------------------
module cpd_prep #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int XW           = 27
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cpd_in_if.sink                         req,
	input  logic                           ready_dn,
	output logic                           v_s1,
	output logic signed [XW-1:0]           x_s1,
	output logic signed [XW-1:0]           y_s1,
	output logic signed [cpd_pkg::ZW-1:0]  z_s1,
	output cpd_pkg::cpd_direct_t           d_s1
);

	localparam int AW   = SAMPLE_WIDTH + 1;
	localparam int WIDE = 33;

	logic                          en;
	logic                          re_neg;
	logic                          im_zero;
	logic signed [XW-1:0]          re_w;
	logic signed [XW-1:0]          im_w;
	logic [AW-1:0]                 re_abs;
	logic [WIDE-1:0]               abs_w;
	logic [cpd_pkg::MAG_W-1:0]     axis_mag;
	logic signed [XW-1:0]          x_n;
	logic signed [XW-1:0]          y_n;
	logic signed [cpd_pkg::ZW-1:0] z_n;
	cpd_pkg::cpd_direct_t          d_n;

	assign en        = !v_s1 || ready_dn;
	assign req.ready = en;

	always_comb begin
		re_w    = XW'(req.real_part);
		im_w    = XW'(req.imag_part);
		re_neg  = req.real_part[SAMPLE_WIDTH-1];
		im_zero = (req.imag_part == '0);
		re_abs  = re_neg ? AW'(-re_w) : AW'(re_w);
		abs_w   = WIDE'(re_abs);
		axis_mag = (abs_w > WIDE'(cpd_pkg::MAG_MAX)) ? cpd_pkg::MAG_MAX
			: abs_w[cpd_pkg::MAG_W-1:0];

		// fold left half plane onto the right, start angle at +-180
		if (re_neg) begin
			x_n = -(re_w <<< cpd_pkg::GUARD_BITS);
			y_n = -(im_w <<< cpd_pkg::GUARD_BITS);
			z_n = req.imag_part[SAMPLE_WIDTH-1] ? -cpd_pkg::Z_HALF_TURN
				: cpd_pkg::Z_HALF_TURN;
		end else begin
			x_n = re_w <<< cpd_pkg::GUARD_BITS;
			y_n = im_w <<< cpd_pkg::GUARD_BITS;
			z_n = '0;
		end

		if (req.req_type == cpd_pkg::REQ_POLAR) begin
			d_n.direct = 1'b1;
			d_n.mag    = req.given_magnitude;
			d_n.phase  = req.given_phase;
		end else begin
			d_n.direct = im_zero;
			d_n.mag    = axis_mag;
			d_n.phase  = re_neg ? cpd_pkg::HALF_TURN : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && req.valid) begin
			x_s1 <= x_n;
			y_s1 <= y_n;
			z_s1 <= z_n;
			d_s1 <= d_n;
		end
	end

endmodule

// ===== design/cpd_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// cpd_cordic_stage
// One vectoring micro-rotation, registered, with its own valid bit.
// ----------------------------------------------------------------------------
module cpd_cordic_stage #(
	parameter int XW  = 27,
	parameter int IDX = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           v_in,
	input  logic signed [XW-1:0]           x_in,
	input  logic signed [XW-1:0]           y_in,
	input  logic signed [cpd_pkg::ZW-1:0]  z_in,
	input  cpd_pkg::cpd_direct_t           d_in,
	output logic                           ready_up,
	input  logic                           ready_dn,
	output logic                           v_s1,
	output logic signed [XW-1:0]           x_s1,
	output logic signed [XW-1:0]           y_s1,
	output logic signed [cpd_pkg::ZW-1:0]  z_s1,
	output cpd_pkg::cpd_direct_t           d_s1
);

	localparam logic signed [cpd_pkg::ZW-1:0] ATAN = cpd_pkg::atan_step(IDX);

	logic                          en;
	logic signed [XW-1:0]          xs;
	logic signed [XW-1:0]          ys;
	logic signed [XW-1:0]          x_n;
	logic signed [XW-1:0]          y_n;
	logic signed [cpd_pkg::ZW-1:0] z_n;

	assign en       = !v_s1 || ready_dn;
	assign ready_up = en;

	// arithmetic shift gives floor division
	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		if (!y_in[XW-1]) begin
			x_n = x_in + ys;
			y_n = y_in - xs;
			z_n = z_in + ATAN;
		end else begin
			x_n = x_in - ys;
			y_n = y_in + xs;
			z_n = z_in - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_in) begin
			x_s1 <= x_n;
			y_s1 <= y_n;
			z_s1 <= z_n;
			d_s1 <= d_in;
		end
	end

endmodule

// ===== design/cpd_post.sv =====
// ----------------------------------------------------------------------------
// cpd_post
// Gain correction (split multiply, then sum and round), phase rounding,
// magnitude saturation and phase wrap. Last stage is the output register.
// ----------------------------------------------------------------------------
module cpd_post #(
	parameter int XW = 27
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           v_in,
	input  logic signed [XW-1:0]           x_in,
	input  logic signed [cpd_pkg::ZW-1:0]  z_in,
	input  cpd_pkg::cpd_direct_t           d_in,
	output logic                           ready_up,
	cpd_out_if.source                      rsp
);

	localparam int GW   = cpd_pkg::GAIN_W;
	localparam int LO   = XW / 2;
	localparam int HI   = XW - LO;
	localparam int PLW  = LO + GW;
	localparam int PHW  = HI + GW;
	localparam int SUMW = XW + GW + 1;

	logic                               en1;
	logic                               en2;
	logic                               v_s1;
	logic [PLW-1:0]                     plo_n;
	logic [PHW-1:0]                     phi_n;
	logic signed [cpd_pkg::ZW-1:0]      zr;
	logic signed [cpd_pkg::PHASE_W-1:0] ph_n;
	logic [PLW-1:0]                     plo_s1;
	logic [PHW-1:0]                     phi_s1;
	logic signed [cpd_pkg::PHASE_W-1:0] ph_s1;
	logic                               direct_s1;
	logic [cpd_pkg::MAG_W-1:0]          dmag_s1;
	logic [SUMW-1:0]                    sum;
	logic [SUMW-1:0]                    q;
	logic [cpd_pkg::MAG_W-1:0]          mag_n;
	logic                               v_s2;
	logic [cpd_pkg::MAG_W-1:0]          mag_s2;
	logic signed [cpd_pkg::PHASE_W-1:0] ph_s2;

	assign en2      = !v_s2 || rsp.ready;
	assign en1      = !v_s1 || en2;
	assign ready_up = en1;

	// x is non-negative after the first rotation; split it into two partials
	always_comb begin
		plo_n = PLW'(x_in[LO-1:0]) * PLW'(cpd_pkg::INV_GAIN);
		phi_n = PHW'(x_in[XW-1:LO]) * PHW'(cpd_pkg::INV_GAIN);
		zr    = z_in + cpd_pkg::Z_ROUND;
		ph_n  = d_in.direct ? d_in.phase : zr[cpd_pkg::ZW-1:cpd_pkg::PHASE_SHIFT];
	end

	always_comb begin
		sum   = (SUMW'(phi_s1) << LO) + SUMW'(plo_s1) + SUMW'(cpd_pkg::MAG_ROUND);
		q     = sum >> cpd_pkg::MAG_SHIFT;
		mag_n = (q > SUMW'(cpd_pkg::MAG_MAX)) ? cpd_pkg::MAG_MAX
			: q[cpd_pkg::MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= v_in;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && v_in) begin
			plo_s1    <= plo_n;
			phi_s1    <= phi_n;
			ph_s1     <= ph_n;
			direct_s1 <= d_in.direct;
			dmag_s1   <= d_in.mag;
		end
		if (en2 && v_s1) begin
			mag_s2 <= direct_s1 ? dmag_s1 : mag_n;
			ph_s2  <= cpd_pkg::wrap_phase(ph_s1);
		end
	end

	assign rsp.valid     = v_s2;
	assign rsp.magnitude = mag_s2;
	assign rsp.phase_deg = ph_s2;

endmodule

// ===== design/complex_to_polar_degrees.sv =====
// ----------------------------------------------------------------------------
// complex_to_polar_degrees
// Rectangular to polar conversion, phase in 1/128 degree, polar pair wrap.
// Pipeline: entry stage, one stage per CORDIC micro-rotation, multiply
//   stage, output register.
// Throughput: one beat per cycle; each stage holds its beat while stalled
//   and accepts a new one as soon as it is free.
// Reset: arst_n clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module complex_to_polar_degrees #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int ROTATION_STEPS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	cpd_in_if.sink    req,
	cpd_out_if.source rsp
);

	localparam int XW = SAMPLE_WIDTH + 11;

	logic                          v_c   [ROTATION_STEPS+1];
	logic                          rdy_c [ROTATION_STEPS+1];
	logic signed [XW-1:0]          x_c   [ROTATION_STEPS+1];
	logic signed [XW-1:0]          y_c   [ROTATION_STEPS+1];
	logic signed [cpd_pkg::ZW-1:0] z_c   [ROTATION_STEPS+1];
	cpd_pkg::cpd_direct_t          d_c   [ROTATION_STEPS+1];

	cpd_prep #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.XW           (XW)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ready_dn (rdy_c[0]),
		.v_s1     (v_c[0]),
		.x_s1     (x_c[0]),
		.y_s1     (y_c[0]),
		.z_s1     (z_c[0]),
		.d_s1     (d_c[0])
	);

	for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_rot
		cpd_cordic_stage #(
			.XW  (XW),
			.IDX (g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.v_in     (v_c[g]),
			.x_in     (x_c[g]),
			.y_in     (y_c[g]),
			.z_in     (z_c[g]),
			.d_in     (d_c[g]),
			.ready_up (rdy_c[g]),
			.ready_dn (rdy_c[g+1]),
			.v_s1     (v_c[g+1]),
			.x_s1     (x_c[g+1]),
			.y_s1     (y_c[g+1]),
			.z_s1     (z_c[g+1]),
			.d_s1     (d_c[g+1])
		);
	end

	cpd_post #(
		.XW (XW)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_in     (v_c[ROTATION_STEPS]),
		.x_in     (x_c[ROTATION_STEPS]),
		.z_in     (z_c[ROTATION_STEPS]),
		.d_in     (d_c[ROTATION_STEPS]),
		.ready_up (rdy_c[ROTATION_STEPS]),
		.rsp      (rsp)
	);

endmodule
